// ===== hdl/aesrt_pkg.sv =====
// AES round transform package: op codes, S-box tables, GF(2^8) helpers.
// Used by every module of aes_round_transform_unit; no dependencies.
package aesrt_pkg;

  typedef enum logic [2:0] {
    OP_ADDKEY   = 3'd0,
    OP_SUB      = 3'd1,
    OP_SHIFT    = 3'd2,
    OP_MIX      = 3'd3,
    OP_INVSUB   = 3'd4,
    OP_INVSHIFT = 3'd5,
    OP_INVMIX   = 3'd6,
    OP_INCR     = 3'd7
  } op_t;

  typedef logic [7:0] byte_t;
  typedef byte_t [15:0] state_t;  // index = FIPS byte number

  localparam logic [7:0] GF_POLY = 8'h1b;

  function automatic byte_t xtime(input byte_t a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t RSBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

endpackage

// ===== hdl/aes_round_transform_unit.sv =====
// Channel | ports                                   | handshake
// in      | in_op, in_block_hi/lo, in_key_hi/lo     | start & !busy
// out     | out_result_hi/lo                        | out_valid, one cycle
// Inputs are registered on accept; the result is registered in the following cycle,
// and one transaction is taken every cycle (busy stays low).
// Reset (rst_n low, synchronous) clears the valid flags only.
// The receiver cannot stall; each result shows for exactly one cycle.
// Depends on aesrt_pkg and aesrt_datapath.
module aes_round_transform_unit
  import aesrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [63:0] in_block_hi,
  input  logic [63:0] in_block_lo,
  input  logic [63:0] in_key_hi,
  input  logic [63:0] in_key_lo,
  output logic        out_valid,
  output logic [63:0] out_result_hi,
  output logic [63:0] out_result_lo
);

  logic         in_vld_r, out_vld_r;
  op_t          op_r;
  logic [127:0] blk_r, key_r, res_r, res_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r  <= op_t'(in_op);
      blk_r <= {in_block_hi, in_block_lo};
      key_r <= {in_key_hi, in_key_lo};
    end
    if (in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  aesrt_datapath u_dp (
    .op  (op_r),
    .blk (blk_r),
    .key (key_r),
    .res (res_nxt)
  );

  assign out_valid     = out_vld_r;
  assign out_result_hi = res_r[127:64];
  assign out_result_lo = res_r[63:0];

endmodule

// ===== hdl/aesrt_mix.sv =====
// MixColumns / InvMixColumns on one 4-byte column.
// Depends on aesrt_pkg (xtime).
module aesrt_mix
  import aesrt_pkg::*;
(
  input  logic          inverse,
  input  byte_t [3:0]   col_in,
  output byte_t [3:0]   col_out
);

  byte_t [3:0] x2, x4, x8, m9, mb, md, me, m3;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      x2[r] = xtime(col_in[r]);
      x4[r] = xtime(x2[r]);
      x8[r] = xtime(x4[r]);
      m3[r] = x2[r] ^ col_in[r];
      m9[r] = x8[r] ^ col_in[r];
      mb[r] = x8[r] ^ x2[r] ^ col_in[r];
      md[r] = x8[r] ^ x4[r] ^ col_in[r];
      me[r] = x8[r] ^ x4[r] ^ x2[r];
    end
    for (int r = 0; r < 4; r++) begin
      if (inverse) begin
        col_out[r] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
      end else begin
        col_out[r] = x2[r] ^ m3[(r+1)%4] ^ col_in[(r+2)%4] ^ col_in[(r+3)%4];
      end
    end
  end

endmodule

// ===== hdl/aesrt_datapath.sv =====
// Single-pass transform of one AES state for the selected operation.
// Depends on aesrt_pkg and aesrt_mix.
module aesrt_datapath
  import aesrt_pkg::*;
(
  input  op_t          op,
  input  logic [127:0] blk,
  input  logic [127:0] key,
  output logic [127:0] res
);

  state_t s, k, t_sub, t_isub, t_sh, t_ish, t_mix, t_out;
  logic   inv_mix;

  assign inv_mix = (op == OP_INVMIX);

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = blk[127-8*i -: 8];
      k[i] = key[127-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) begin
      t_sub[i]  = SBOX[s[i]];
      t_isub[i] = RSBOX[s[i]];
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t_sh[r+4*c]  = s[r + 4*((c + r) % 4)];
        t_ish[r+4*c] = s[r + 4*((c + 4 - r) % 4)];
      end
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_col
    aesrt_mix u_mix (
      .inverse (inv_mix),
      .col_in  (s[4*c+3:4*c]),
      .col_out (t_mix[4*c+3:4*c])
    );
  end

  always_comb begin
    case (op)
      OP_ADDKEY:   t_out = s ^ k;
      OP_SUB:      t_out = t_sub;
      OP_SHIFT:    t_out = t_sh;
      OP_INVSUB:   t_out = t_isub;
      OP_INVSHIFT: t_out = t_ish;
      OP_MIX,
      OP_INVMIX:   t_out = t_mix;
      default:     t_out = s;
    endcase
    for (int i = 0; i < 16; i++) begin
      res[127-8*i -: 8] = t_out[i];
    end
    if (op == OP_INCR) begin
      res = blk + 128'd1;
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench for aes_round_transform_unit: directed and random AES round transactions.
// Predicts each result with its own GF(2^8) arithmetic; depends on aesrt_pkg (op_t).
`timescale 1ns / 1ps

module tb_top;
  import aesrt_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_op = 3'd0;
  logic [63:0] in_block_hi = '0, in_block_lo = '0, in_key_hi = '0, in_key_lo = '0;
  logic        out_valid;
  logic [63:0] out_result_hi, out_result_lo;

  logic [127:0] expected_states[$];
  int unsigned  n_errors = 0;
  int unsigned  n_checked = 0;
  int unsigned  n_sent = 0;
  int unsigned  idle_pct = 0;

  always #1 clk = ~clk;

  aes_round_transform_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_block_hi(in_block_hi), .in_block_lo(in_block_lo),
    .in_key_hi(in_key_hi), .in_key_lo(in_key_lo),
    .out_valid(out_valid), .out_result_hi(out_result_hi), .out_result_lo(out_result_lo)
  );

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] ginv(logic [7:0] x);
    logic [7:0] r;
    r = 8'h01;
    // x^254 = multiplicative inverse, 0 maps to 0
    for (int k = 0; k < 254; k++) r = gmul(r, x);
    return (x == 8'h00) ? 8'h00 : r;
  endfunction

  function automatic logic [7:0] rol8(logic [7:0] x, int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_fwd(logic [7:0] x);
    logic [7:0] v;
    v = ginv(x);
    return v ^ rol8(v, 1) ^ rol8(v, 2) ^ rol8(v, 3) ^ rol8(v, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] sbox_inv(logic [7:0] x);
    return ginv(rol8(x, 1) ^ rol8(x, 3) ^ rol8(x, 6) ^ 8'h05);
  endfunction

  logic [7:0] fwd_tab[256], inv_tab[256];
  initial begin
    for (int i = 0; i < 256; i++) begin
      fwd_tab[i] = sbox_fwd(i[7:0]);
      inv_tab[i] = sbox_inv(i[7:0]);
    end
  end

  // byte i of the state sits at bits 127-8i of {hi,lo}
  function automatic logic [127:0] round_transform(op_t op, logic [127:0] st,
                                                   logic [127:0] rk);
    logic [7:0] s[16], t[16], k[16];
    logic [7:0] m[4];
    logic [127:0] res;
    if (op == OP_INCR) return st + 128'd1;
    for (int i = 0; i < 16; i++) begin
      s[i] = st[127 - 8*i -: 8];
      k[i] = rk[127 - 8*i -: 8];
    end
    if (op == OP_MIX) begin
      m[0] = 8'h02; m[1] = 8'h03; m[2] = 8'h01; m[3] = 8'h01;
    end else begin
      m[0] = 8'h0e; m[1] = 8'h0b; m[2] = 8'h0d; m[3] = 8'h09;
    end
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        case (op)
          OP_ADDKEY:   t[r+4*c] = s[r+4*c] ^ k[r+4*c];
          OP_SUB:      t[r+4*c] = fwd_tab[s[r+4*c]];
          OP_INVSUB:   t[r+4*c] = inv_tab[s[r+4*c]];
          OP_SHIFT:    t[r+4*c] = s[r + 4*((c + r) % 4)];
          OP_INVSHIFT: t[r+4*c] = s[r + 4*((c + 4 - r) % 4)];
          default:     t[r+4*c] = gmul(m[0], s[r+4*c]) ^ gmul(m[1], s[(r+1)%4 + 4*c])
                                  ^ gmul(m[2], s[(r+2)%4 + 4*c]) ^ gmul(m[3], s[(r+3)%4 + 4*c]);
        endcase
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = t[i];
    return res;
  endfunction

  // one transaction; start stays high across back-to-back sends
  task automatic send_block(op_t op, logic [127:0] st, logic [127:0] rk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_op       <= op;
    {in_block_hi, in_block_lo} <= st;
    {in_key_hi, in_key_lo}     <= rk;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_states.push_back(round_transform(op, st, rk));
    n_sent++;
  endtask

  task automatic go_quiet();
    start <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_states.size() == 0) begin
        $display("%0t: unexpected result exp=none act=%h_%h", $time,
                 out_result_hi, out_result_lo);
        n_errors++;
      end else begin
        logic [127:0] e;
        e = expected_states.pop_front();
        n_checked++;
        if (out_result_hi !== e[127:64]) begin
          $display("%0t: result_hi mismatch exp=%h act=%h", $time, e[127:64], out_result_hi);
          n_errors++;
        end
        if (out_result_lo !== e[63:0]) begin
          $display("%0t: result_lo mismatch exp=%h act=%h", $time, e[63:0], out_result_lo);
          n_errors++;
        end
      end
    end
  end

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic test_directed();
    logic [127:0] ones, fips;
    ones = '1;
    fips = 128'h00112233445566778899aabbccddeeff;
    idle_pct = 0;
    for (int o = 0; o < 8; o++) begin
      send_block(op_t'(o), '0, ones);
      send_block(op_t'(o), ones, '0);
    end
    send_block(OP_ADDKEY, fips, 128'h000102030405060708090a0b0c0d0e0f);
    send_block(OP_MIX, 128'hdb135345f20a225c01010101c6c6c6c6, rand128());
    send_block(OP_INVMIX, 128'h8e4da1bc9fdc589d01010101c6c6c6c6, rand128());
    send_block(OP_INCR, 128'h00000000000000ffffffffffffffffff, rand128());
    send_block(OP_INCR, 128'h0000000000000000fffffffffffffffe, rand128());
    send_block(OP_SHIFT, fips, ones);
    send_block(OP_INVSHIFT, fips, ones);
    go_quiet();
  endtask

  // random ops on random content, each state mostly chained from the previous result
  task automatic test_random(int n, int pct);
    logic [127:0] st;
    idle_pct = pct;
    st = rand128();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) st = rand128();
      case ($urandom_range(9))
        0:       st = {64'hffffffffffffffff, $urandom, $urandom};
        1:       st = {$urandom, $urandom, 64'hffffffffffffffff};
        default: ;
      endcase
      send_block(op_t'($urandom_range(7)), st, rand128());
      st = expected_states.size() ? expected_states[$] : st;
    end
    go_quiet();
  endtask

  task automatic drain();
    while (expected_states.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain();
    test_random(400, 0);
    drain();
    test_random(400, 56);
    drain();
    test_random(400, 0);
    test_random(400, 34);
    drain();
    repeat (8) @(posedge clk);
    $display("sent %0d transactions over all 8 ops, %0d results checked",
             n_sent, n_checked);
    if (n_errors == 0 && expected_states.size() == 0)
      $display("aes_round_transform_unit regression: pass");
    else $display("aes_round_transform_unit regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("aes_round_transform_unit regression: fail");
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/aesrt_pkg.sv
hdl/aesrt_mix.sv
hdl/aesrt_datapath.sv
hdl/aes_round_transform_unit.sv
sim/tb_top.sv
